FILE: src/e2c_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared default table sizes, field widths, operation codes and status codes of the edge list to
// CSR builder.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Default table sizes
    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 4096;

    // Field widths of the stream words
    localparam int OP_W     = 3;
    localparam int NODE_W   = 10;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 13;
    localparam int STATUS_W = 2;
    localparam int NCFG_W   = 11;
    localparam int COL_W    = 10;

    // Operation codes
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD  = 3'd1;
    localparam logic [OP_W-1:0] OP_PLACE  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_OFF = 3'd3;
    localparam logic [OP_W-1:0] OP_RD_COL = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PHASE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

endpackage

FILE: src/e2c_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2c_alu
// Shared add and compare unit: used for degree increments, the running sum
// of the build pass, and cursor advance with row bound check.
// ----------------------------------------------------------------------------
module e2c_alu #(
    parameter int W = 13
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    output logic [W-1:0] o_sum,
    output logic         o_ge
);

    // One adder and one magnitude compare
    assign o_sum = i_a + i_b;
    assign o_ge  = (i_a >= i_c);

endmodule

FILE: src/edge_list_to_csr_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_list_to_csr_builder_top
// Builds a CSR graph from an edge list: count pass, offset build, place pass,
// and read commands, all around one shared add and compare unit.
// ----------------------------------------------------------------------------
// Flow: count, place and read words are accepted, read from memory, then
//   executed through the shared adder once the result slot is free; build
//   writes one offset entry per cycle through the offset table, its last entry
//   waiting for a free result slot. Ready is low while a word is in work.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the
//   MAX_NODES + 1 offset entries before ready rises.
// ----------------------------------------------------------------------------
module edge_list_to_csr_builder_top
    import e2c_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: node_count
    input  logic              i_cfg_wen,
    input  logic [NCFG_W-1:0] i_cfg_wdata,
    // input words
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // src[9:0], dst[19:10], index[31:20]
    input  logic [OP_W-1:0]   i_s_tuser,   // op[2:0]
    // result words
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,   // value[12:0], zero[15:13]
    output logic [STATUS_W-1:0] o_m_tuser  // status[1:0]
);

    localparam int NODE_AW = $clog2(MAX_NODES + 1);
    localparam int CUR_AW  = $clog2(MAX_NODES);
    localparam int EDGE_AW = $clog2(MAX_EDGES);
    localparam int CNT_W   = $clog2(MAX_EDGES + 1);
    localparam int OFF_DEPTH = MAX_NODES + 1;
    localparam int NC_RST  = (1024 > MAX_NODES) ? MAX_NODES : 1024;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_BUILD = 2'd3;

    // Memories
    logic [CNT_W-1:0] r_off_mem [OFF_DEPTH];
    logic [CNT_W-1:0] r_cur_mem [MAX_NODES];
    logic [COL_W-1:0] r_col_mem [MAX_EDGES];

    logic [CNT_W-1:0] r_off_q;
    logic [CNT_W-1:0] r_cur_q;
    logic [COL_W-1:0] r_col_q;

    // Control and item registers
    logic [1:0]         r_state, n_state;
    logic [NODE_AW-1:0] r_clr_addr;
    logic [NODE_AW-1:0] r_node_count;
    logic               r_phase;
    logic [CNT_W-1:0]   r_edges;
    logic [NODE_AW-1:0] r_i;
    logic [CNT_W-1:0]   r_acc;
    logic [OP_W-1:0]    r_op;
    logic [NODE_W-1:0]  r_src;
    logic [COL_W-1:0]   r_dst;
    logic [INDEX_W-1:0] r_idx;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic [STATUS_W-1:0] r_out_status;

    // Input word fields
    logic [NODE_W-1:0]  in_src;
    logic [COL_W-1:0]   in_dst;
    logic [INDEX_W-1:0] in_idx;
    logic [OP_W-1:0]    in_op;
    assign in_src = i_s_tdata[9:0];
    assign in_dst = i_s_tdata[19:10];
    assign in_idx = i_s_tdata[31:20];
    assign in_op  = i_s_tuser;

    logic accept;
    logic slot_free;
    logic exec_fire;
    logic build_final;
    logic build_step;
    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign slot_free   = !r_out_valid || i_m_tready;
    assign exec_fire   = (r_state == S_EXEC) && slot_free;
    assign build_final = (r_i == r_node_count);
    assign build_step  = (r_state == S_BUILD) && (!build_final || slot_free);

    // Shared unit
    logic [CNT_W-1:0] alu_a, alu_b, alu_c, alu_sum;
    logic             alu_ge;

    e2c_alu #(.W(CNT_W)) u_alu (
        .i_a  (alu_a),
        .i_b  (alu_b),
        .i_c  (alu_c),
        .o_sum(alu_sum),
        .o_ge (alu_ge)
    );

    // Steer operands into the shared unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        alu_c = '0;
        if (r_state == S_EXEC) begin
            alu_a = (r_op == OP_PLACE) ? r_cur_q : r_off_q;
            alu_b = CNT_W'(1);
            alu_c = r_off_q;
        end else if (r_state == S_BUILD) begin
            alu_a = r_acc;
            alu_b = r_off_q;
        end
    end

    // Execute: checks, result and side effects of one word
    logic               src_bad;
    logic               cnt_ok, place_ok, build_go;
    logic [VALUE_W-1:0] res_value;
    logic [STATUS_W-1:0] res_status;
    assign src_bad = 32'(r_src) >= 32'(r_node_count);

    always_comb begin
        cnt_ok     = 1'b0;
        place_ok   = 1'b0;
        build_go   = 1'b0;
        res_value  = '0;
        res_status = ST_OK;
        case (r_op)
            OP_COUNT: begin
                if (src_bad) begin
                    res_status = ST_RANGE;
                end else if (r_phase) begin
                    res_status = ST_PHASE;
                end else if (32'(r_edges) >= 32'(MAX_EDGES)) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    cnt_ok    = 1'b1;
                    res_value = VALUE_W'(32'(r_edges) + 32'd1);
                end
            end
            OP_BUILD: begin
                if (r_phase) begin
                    res_status = ST_PHASE;
                end else begin
                    build_go = 1'b1;
                end
            end
            OP_PLACE: begin
                if (src_bad) begin
                    res_status = ST_RANGE;
                end else if (!r_phase) begin
                    res_status = ST_PHASE;
                end else if (alu_ge || (32'(r_cur_q) >= 32'(MAX_EDGES))) begin
                    res_status = ST_OVERFLOW;
                end else begin
                    place_ok  = 1'b1;
                    res_value = VALUE_W'(r_cur_q);
                end
            end
            OP_RD_OFF: begin
                if (32'(r_idx) > 32'(r_node_count)) begin
                    res_status = ST_RANGE;
                end else begin
                    res_value = VALUE_W'(r_off_q);
                end
            end
            OP_RD_COL: begin
                if (!r_phase) begin
                    res_status = ST_PHASE;
                end else if ((32'(r_idx) >= 32'(r_edges)) ||
                             (32'(r_idx) >= 32'(MAX_EDGES))) begin
                    res_status = ST_RANGE;
                end else begin
                    res_value = VALUE_W'(r_col_q);
                end
            end
            default: begin
                res_status = ST_PHASE;
            end
        endcase
    end

    // Offset memory port selection
    logic               off_we, off_re;
    logic [NODE_AW-1:0] off_waddr, off_raddr;
    logic [CNT_W-1:0]   off_wdata;
    logic [NODE_AW-1:0] src_next;
    assign src_next = NODE_AW'(r_src) + NODE_AW'(1);

    always_comb begin
        off_we    = 1'b0;
        off_waddr = r_clr_addr;
        off_wdata = '0;
        if (r_state == S_CLEAR) begin
            off_we = 1'b1;
        end else if (exec_fire && cnt_ok) begin
            off_we    = 1'b1;
            off_waddr = src_next;
            off_wdata = alu_sum;
        end else if (build_step) begin
            off_we    = 1'b1;
            off_waddr = r_i;
            off_wdata = alu_sum;
        end
    end

    always_comb begin
        off_re    = 1'b0;
        off_raddr = r_i + NODE_AW'(1);
        if (accept) begin
            off_re    = 1'b1;
            off_raddr = (in_op == OP_RD_OFF) ? NODE_AW'(in_idx)
                                             : NODE_AW'(in_src) + NODE_AW'(1);
        end else if (exec_fire && build_go) begin
            off_re    = 1'b1;
            off_raddr = NODE_AW'(1);
        end else if (build_step && !build_final) begin
            off_re = 1'b1;
        end
    end

    // Offset table
    always_ff @(posedge i_clk) begin
        if (off_we) begin
            r_off_mem[off_waddr] <= off_wdata;
        end
        if (off_re) begin
            r_off_q <= r_off_mem[off_raddr];
        end
    end

    // Cursor table: written by build and place, read at accept
    always_ff @(posedge i_clk) begin
        if (build_step) begin
            r_cur_mem[CUR_AW'(r_i - NODE_AW'(1))] <= r_acc;
        end else if (exec_fire && place_ok) begin
            r_cur_mem[CUR_AW'(r_src)] <= alu_sum;
        end
        if (accept) begin
            r_cur_q <= r_cur_mem[CUR_AW'(in_src)];
        end
    end

    // Column store
    always_ff @(posedge i_clk) begin
        if (exec_fire && place_ok) begin
            r_col_mem[EDGE_AW'(r_cur_q)] <= r_dst;
        end
        if (accept) begin
            r_col_q <= r_col_mem[EDGE_AW'(in_idx)];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == NODE_AW'(MAX_NODES)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_fire) begin
                    n_state = build_go ? S_BUILD : S_IDLE;
                end
            end
            S_BUILD: begin
                if (build_step && build_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_node_count <= NODE_AW'(NC_RST);
            r_phase      <= 1'b0;
            r_edges      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + NODE_AW'(1);
            end
            // clamp node_count into 1..MAX_NODES
            if (i_cfg_wen) begin
                if (i_cfg_wdata == '0) begin
                    r_node_count <= NODE_AW'(1);
                end else if (32'(i_cfg_wdata) > 32'(MAX_NODES)) begin
                    r_node_count <= NODE_AW'(MAX_NODES);
                end else begin
                    r_node_count <= NODE_AW'(i_cfg_wdata);
                end
            end
            if (exec_fire && cnt_ok) begin
                r_edges <= r_edges + CNT_W'(1);
            end
            if (build_step && build_final) begin
                r_phase <= 1'b1;
            end
            // hold the result word until taken
            if ((exec_fire && !build_go) || (build_step && build_final)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item, build and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= in_op;
            r_src <= in_src;
            r_dst <= in_dst;
            r_idx <= in_idx;
        end
        if (exec_fire && build_go) begin
            r_i   <= NODE_AW'(1);
            r_acc <= '0;
        end else if (build_step) begin
            r_i   <= r_i + NODE_AW'(1);
            r_acc <= alu_sum;
        end
        if (exec_fire && !build_go) begin
            r_out_value  <= res_value;
            r_out_status <= res_status;
        end else if (build_step && build_final) begin
            r_out_value  <= VALUE_W'(alu_sum);
            r_out_status <= ST_OK;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_value};
    assign o_m_tuser  = r_out_status;

    // Accepted word goes straight to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted word did not enter execute");

    // Placing phase never falls back to counting
    a_phase_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |=> r_phase)
        else $error("phase returned to counting");

    // Edge count stays within the column store
    a_edges_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edges) <= 32'(MAX_EDGES))
        else $error("edge count beyond store depth");

    // New results come only from execute or the last build step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_EXEC || $past(r_state) == S_BUILD))
        else $error("result raised outside execute or build");

    // No result while the offset table is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result pending during clearing pass");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge list to CSR builder. A short stimulus table
// walks reset values, field extremes, every op but build, and the range and
// phase statuses. Random count words then fill part of the edge store. One
// build follows, and after it random place and read words run. Every result
// word is compared with the table's expected result or with a behavioral copy
// of the builder kept in this file. Both stream sides stall at random early on.
// ----------------------------------------------------------------------------
module tb_top;
    import e2c_pkg::*;

    // Default edge store; the count pass stops well short of it
    localparam int EDGE_CAP      = MAX_EDGES_DEF;
    localparam int COUNT_TARGET  = 1200;
    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam bit TYPED         = 1'b1;
    localparam bit PREDICTED     = 1'b0;

    // Op codes the block must reject
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
    } t_csr_result;

    typedef struct packed {
        logic                is_cfg;
        logic [NCFG_W-1:0]   cfg;
        logic [OP_W-1:0]     op;
        logic [NODE_W-1:0]   src;
        logic [NODE_W-1:0]   dst;
        logic [INDEX_W-1:0]  idx;
        logic                typed;
        t_csr_result         want;
    } t_plan_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wen;
    logic [NCFG_W-1:0]   i_cfg_wdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [31:0]         i_s_tdata;
    logic [OP_W-1:0]     i_s_tuser;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [15:0]         o_m_tdata;
    logic [STATUS_W-1:0] o_m_tuser;

    // Builder copy: tables, phase, edge count and node count in use
    logic [VALUE_W-1:0] row_start [0:MAX_NODES_DEF];
    logic [VALUE_W-1:0] row_next  [0:MAX_NODES_DEF-1];
    logic [COL_W-1:0]   col_mem   [0:EDGE_CAP-1];
    logic               placing;
    logic [VALUE_W-1:0] edges_seen;
    logic [NCFG_W-1:0]  nodes_used;
    int unsigned        placed_pos [$];

    t_csr_result csr_results_due [$];
    t_plan_row   opening_plan [$];
    int unsigned mismatch_count;
    int unsigned words_sent;
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned hold_request;

    edge_list_to_csr_builder_top #(
        .MAX_NODES (MAX_NODES_DEF),
        .MAX_EDGES (EDGE_CAP)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Advance the builder copy by one word and return its result
    function automatic t_csr_result predict_csr_result(input logic [OP_W-1:0] op,
            input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst,
            input logic [INDEX_W-1:0] idx);
        t_csr_result r;
        int unsigned s;
        int unsigned pos;
        int unsigned i;
        r = '0;
        s = src;
        case (op)
            OP_COUNT: begin
                if (s >= nodes_used) begin
                    r.status = ST_RANGE;
                end else if (placing) begin
                    r.status = ST_PHASE;
                end else if (edges_seen >= EDGE_CAP) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    row_start[s + 1] = row_start[s + 1] + VALUE_W'(1);
                    edges_seen = edges_seen + VALUE_W'(1);
                    r.value = edges_seen;
                end
            end
            OP_BUILD: begin
                if (placing) begin
                    r.status = ST_PHASE;
                end else begin
                    // running sum, then each row's start becomes its cursor
                    for (i = 1; i <= nodes_used; i++)
                        row_start[i] = row_start[i] + row_start[i - 1];
                    for (i = 0; i < nodes_used; i++)
                        row_next[i] = row_start[i];
                    placing = 1'b1;
                    r.value = row_start[nodes_used];
                end
            end
            OP_PLACE: begin
                if (s >= nodes_used) begin
                    r.status = ST_RANGE;
                end else if (!placing) begin
                    r.status = ST_PHASE;
                end else begin
                    pos = row_next[s];
                    if (pos >= row_start[s + 1] || pos >= EDGE_CAP) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        col_mem[pos] = dst;
                        row_next[s] = VALUE_W'(pos + 1);
                        placed_pos.push_back(pos);
                        r.value = VALUE_W'(pos);
                    end
                end
            end
            OP_RD_OFF: begin
                if (idx > nodes_used)
                    r.status = ST_RANGE;
                else
                    r.value = row_start[idx];
            end
            OP_RD_COL: begin
                if (!placing)
                    r.status = ST_PHASE;
                else if (idx >= edges_seen || idx >= EDGE_CAP)
                    r.status = ST_RANGE;
                else
                    r.value = VALUE_W'(col_mem[idx]);
            end
            default: begin
                r.status = ST_PHASE;
            end
        endcase
        return r;
    endfunction

    function automatic t_plan_row word_row(input logic [OP_W-1:0] op,
            input int unsigned src, input int unsigned dst, input int unsigned idx,
            input bit typed, input int unsigned value, input logic [STATUS_W-1:0] status);
        t_plan_row row;
        row = '0;
        row.op = op;
        row.src = NODE_W'(src);
        row.dst = NODE_W'(dst);
        row.idx = INDEX_W'(idx);
        row.typed = typed;
        row.want.value = VALUE_W'(value);
        row.want.status = status;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input int unsigned wdata);
        t_plan_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.cfg = NCFG_W'(wdata);
        return row;
    endfunction

    // Spread node counts over the extremes, clamped values and the middle
    function automatic logic [NCFG_W-1:0] pick_node_count();
        logic [NCFG_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = 11'd1;
            1:       v = '0;
            2:       v = '1;
            3:       v = NCFG_W'($urandom_range(0, 2047));
            4:       v = NCFG_W'($urandom_range(1, 64));
            default: v = 11'd1024;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
            input int unsigned want);
        mismatch_count++;
        $display("tb: %s mismatch at %0t: got %0d, expected %0d",
                 what, $time, got, want);
    endtask

    // Write node_count only with the block idle: all results back, then settle
    task automatic set_node_count(input logic [NCFG_W-1:0] wdata);
        i_s_tvalid <= 1'b0;
        while (csr_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= wdata;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        if (wdata < 1)
            nodes_used = 11'd1;
        else if (wdata > MAX_NODES_DEF)
            nodes_used = NCFG_W'(MAX_NODES_DEF);
        else
            nodes_used = wdata;
    endtask

    // Queue the expected result, then offer the word until it is taken
    task automatic send_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] src,
            input logic [NODE_W-1:0] dst, input logic [INDEX_W-1:0] idx,
            input bit typed, input t_csr_result want);
        t_csr_result guess;
        case (words_sent / 700)
            0: begin
                send_idle = 28;
                recv_idle = 77;
            end
            1: begin
                send_idle = 77;
                recv_idle = 28;
            end
            default: begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
        guess = predict_csr_result(op, src, dst, idx);
        csr_results_due.push_back(typed ? want : guess);
        if ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {idx, dst, src};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
    endtask

    // Result side: check each accepted word, stall at random or on request
    initial begin
        int unsigned hold_left;
        t_csr_result want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                if (csr_results_due.size() == 0) begin
                    report_mismatch("unexpected word", o_m_tdata, 0);
                end else begin
                    want = csr_results_due.pop_front();
                    if (o_m_tdata !== {{(16 - VALUE_W){1'b0}}, want.value})
                        report_mismatch("value", o_m_tdata, want.value);
                    if (o_m_tuser !== want.status)
                        report_mismatch("status", o_m_tuser, want.status);
                end
            end
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Stimulus: opening table, count pass, build, place pass
    initial begin
        logic [OP_W-1:0]    op;
        logic [NODE_W-1:0]  src;
        logic [NODE_W-1:0]  dst;
        logic [INDEX_W-1:0] idx;
        int unsigned        r;
        int unsigned        n;
        int unsigned        build_nodes;
        int unsigned        cursor_limit;
        int unsigned        hot_src [6];

        i_rst_n      = 1'b0;
        i_cfg_wen    = 1'b0;
        i_cfg_wdata  = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        i_m_tready   = 1'b0;
        mismatch_count = 0;
        words_sent   = 0;
        send_idle    = 28;
        recv_idle    = 77;
        hold_request = 0;
        for (n = 0; n <= MAX_NODES_DEF; n++)
            row_start[n] = '0;
        for (n = 0; n < MAX_NODES_DEF; n++)
            row_next[n] = '0;
        for (n = 0; n < EDGE_CAP; n++)
            col_mem[n] = '0;
        placing    = 1'b0;
        edges_seen = '0;
        nodes_used = NCFG_W'(MAX_NODES_DEF);

        // Opening table: reset values, field extremes, range and phase statuses
        opening_plan.push_back(cfg_row(0));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 0, TYPED, 0, ST_OK));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 1, TYPED, 0, ST_OK));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 2, TYPED, 0, ST_RANGE));
        opening_plan.push_back(word_row(OP_RD_OFF, 1023, 1023, 4095, TYPED, 0, ST_RANGE));
        opening_plan.push_back(word_row(OP_COUNT, 0, 1023, 4095, TYPED, 1, ST_OK));
        opening_plan.push_back(word_row(OP_COUNT, 1, 0, 0, TYPED, 0, ST_RANGE));
        opening_plan.push_back(word_row(OP_COUNT, 1023, 1023, 4095, TYPED, 0, ST_RANGE));
        opening_plan.push_back(word_row(OP_PLACE, 0, 5, 0, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RD_COL, 0, 0, 0, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RSVD_5, 1023, 1023, 4095, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RSVD_6, 0, 0, 0, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RSVD_7, 1023, 1023, 4095, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 1, TYPED, 1, ST_OK));
        opening_plan.push_back(cfg_row(2047));
        opening_plan.push_back(word_row(OP_COUNT, 1023, 0, 0, TYPED, 2, ST_OK));
        opening_plan.push_back(word_row(OP_COUNT, 1023, 1023, 4095, TYPED, 3, ST_OK));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 1024, TYPED, 2, ST_OK));
        opening_plan.push_back(word_row(OP_RD_OFF, 0, 0, 1025, TYPED, 0, ST_RANGE));
        opening_plan.push_back(cfg_row(1024));
        opening_plan.push_back(word_row(OP_COUNT, 512, 341, 2730, PREDICTED, 0, ST_OK));
        opening_plan.push_back(word_row(OP_PLACE, 1023, 682, 1365, TYPED, 0, ST_PHASE));
        opening_plan.push_back(word_row(OP_RD_COL, 0, 0, 4095, TYPED, 0, ST_PHASE));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_plan[i]) begin
            if (opening_plan[i].is_cfg)
                set_node_count(opening_plan[i].cfg);
            else
                send_word(opening_plan[i].op, opening_plan[i].src, opening_plan[i].dst,
                          opening_plan[i].idx, opening_plan[i].typed, opening_plan[i].want);
        end

        // Count pass: mostly good edges until the target count
        while (edges_seen < COUNT_TARGET) begin
            set_node_count(pick_node_count());
            for (n = 0; n < 250 && edges_seen < COUNT_TARGET; n++) begin
                r   = $urandom_range(0, 99);
                dst = NODE_W'($urandom_range(0, 1023));
                idx = INDEX_W'($urandom_range(0, 4095));
                src = NODE_W'($urandom_range(0, nodes_used - 1));
                op  = OP_COUNT;
                if (r >= 86 && r < 90) begin
                    if (nodes_used < MAX_NODES_DEF)
                        src = NODE_W'($urandom_range(nodes_used, 1023));
                end else if (r >= 90 && r < 95) begin
                    op  = OP_RD_OFF;
                    idx = INDEX_W'(r[0] ? $urandom_range(0, nodes_used)
                                        : $urandom_range(0, 4095));
                end else if (r >= 95 && r < 97) begin
                    op  = r[0] ? OP_PLACE : OP_RD_COL;
                    src = NODE_W'($urandom_range(0, 1023));
                end else if (r >= 97) begin
                    op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
                end
                send_word(op, src, dst, idx, PREDICTED, '0);
            end
        end

        // A few more counts on row zero
        repeat (3) send_word(OP_COUNT, '0, NODE_W'($urandom_range(0, 1023)),
                             INDEX_W'($urandom_range(0, 4095)), PREDICTED, '0);

        // One build, then build and count are out of phase
        build_nodes = $urandom_range(960, 1024);
        set_node_count(NCFG_W'(build_nodes));
        send_word(OP_BUILD, '0, '0, '0, PREDICTED, '0);
        send_word(OP_BUILD, '0, '0, '0, TYPED, '{value: '0, status: ST_PHASE});
        send_word(OP_COUNT, '0, '0, '0, TYPED, '{value: '0, status: ST_PHASE});

        // A few hot rows run past their counted degree
        foreach (hot_src[k])
            hot_src[k] = $urandom_range(0, build_nodes - 1);

        // Place pass: places, column reads of placed slots, noise
        for (int round = 0; round < 3; round++) begin
            if (round != 0)
                set_node_count(pick_node_count());
            else
                hold_request = HOLD_CYCLES;
            repeat (200) begin
                // only rows that the build gave a cursor are placed
                cursor_limit = (nodes_used < build_nodes) ? nodes_used : build_nodes;
                r   = $urandom_range(0, 99);
                dst = NODE_W'($urandom_range(0, 1023));
                idx = INDEX_W'($urandom_range(0, 4095));
                src = NODE_W'($urandom_range(0, cursor_limit - 1));
                op  = OP_PLACE;
                if (r < 40) begin
                    src = NODE_W'(hot_src[$urandom_range(0, 5)]);
                end else if (r >= 60 && r < 65) begin
                    if (nodes_used < MAX_NODES_DEF)
                        src = NODE_W'($urandom_range(nodes_used, 1023));
                end else if (r >= 65 && r < 85) begin
                    op = OP_RD_COL;
                    if (placed_pos.size() != 0 && $urandom_range(0, 3) != 0)
                        idx = INDEX_W'(placed_pos[$urandom_range(0, placed_pos.size() - 1)]);
                    else
                        idx = INDEX_W'($urandom_range(edges_seen, 4095));
                end else if (r >= 85 && r < 93) begin
                    op  = OP_RD_OFF;
                    idx = INDEX_W'(r[0] ? $urandom_range(0, nodes_used)
                                        : $urandom_range(0, 4095));
                end else if (r >= 93 && r < 96) begin
                    op  = OP_COUNT;
                    src = '0;
                end else if (r >= 96 && r < 98) begin
                    op = OP_BUILD;
                end else if (r >= 98) begin
                    op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
                end
                send_word(op, src, dst, idx, PREDICTED, '0);
            end
        end

        // Drain, let the pipe settle, then decide
        i_s_tvalid <= 1'b0;
        while (csr_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
src/e2c_pkg.sv
src/e2c_alu.sv
src/edge_list_to_csr_builder_top.sv
verif/tb_top.sv
